@@ rtl/core/lsfe_pkg.sv @@
// Shared types and constants of the Lagrange shape-function evaluator.
`timescale 1ns / 1ps
package lsfe_pkg;
	localparam int MAX_NODES = 4;
	localparam int MAX_DIM   = 3;

	localparam logic [2:0] REG_NODE_COUNT = 3'd0;
	localparam logic [2:0] REG_DIMENSION  = 3'd1;
	localparam logic [2:0] REG_NODE_POS_0 = 3'd2;
	localparam logic [2:0] REG_NODE_POS_3 = 3'd5;

	// Datapath operations, issued by the controller.
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_LOAD   = 3'd1, // num <= 1, den <= 1, sum <= 0 when clr
		OP_NUMMUL = 3'd2, // num <= num * (x - node k)
		OP_DENMUL = 3'd3, // den <= den * (node j - node k)
		OP_SUMADD = 3'd4, // sum <= sum + num
		OP_DIVGO  = 3'd5, // start divider
		OP_PMUL   = 3'd6, // acc <= acc * v
		OP_SETACC = 3'd7  // acc <= v
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
		logic [1:0] j;
		logic [1:0] k;
		logic       deriv;
		logic       clr;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic coincide;
	} stat_t;
endpackage

@@ rtl/core/lsfe_div.sv @@
// Restoring divider producing the rounded, capped Q ratio.
`timescale 1ns / 1ps
module lsfe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	input  logic        frac32,
	output logic        busy,
	output logic [32:0] quo
);
	// long division one bit a cycle over num*2^(frac+1), quotient capped at 2^32
	logic [6:0]   cnt_q;
	logic [97:0]  rem_q;
	logic [63:0]  den_q;
	logic [97:0]  n_q;
	logic [34:0]  q_q;
	logic         ovf_q;
	logic [98:0]  trial;
	logic [34:0]  qn;

	assign trial = {rem_q, n_q[97]} - {35'd0, den_q};
	assign qn = {q_q[33:0], ~trial[98]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd98;
		end else if (cnt_q != 7'd0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			n_q <= frac32 ? {1'b0, num, 33'd0} : {17'd0, num, 17'd0};
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (cnt_q != 7'd0) begin
			rem_q <= trial[98] ? {rem_q[96:0], n_q[97]} : trial[97:0];
			n_q <= {n_q[96:0], 1'b0};
			q_q <= qn;
			if (q_q[34]) ovf_q <= 1'b1;
		end
	end

	logic [35:0] rq;
	assign rq = {1'b0, q_q} + 36'd1;
	assign busy = cnt_q != 7'd0;
	assign quo = (ovf_q || q_q[34] || rq[35:1] >= 35'h100000000) ? 33'h100000000 : rq[33:1];
endmodule

@@ rtl/core/lsfe_datapath.sv @@
// Datapath: node registers, shared multiplier, divider and basis tables.
`timescale 1ns / 1ps
module lsfe_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [17:0]        cfg_data,
	input  logic               load,
	input  logic [17:0]        coord_r,
	input  logic [17:0]        coord_s,
	input  logic [17:0]        coord_t,
	input  logic [2:0]         n_eff,
	input  lsfe_pkg::cmd_t     cmd,
	input  logic               wr_basis,
	output lsfe_pkg::stat_t    stat,
	output logic [31:0]        val,
	output logic               flag,
	output logic [2:0]         node_count_q,
	output logic [1:0]         dimension_q
);
	logic signed [17:0] pos_q [4];
	logic signed [17:0] x_q [3];
	logic signed [63:0] num_q, den_q, sum_q, acc_q;
	logic signed [31:0] v_q [3][4];
	logic               f_q [3][4];
	logic               dstart_q, accf_q;
	logic               dbusy;
	logic [32:0]        dquo;
	logic               neg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 3'd2;
			dimension_q <= 2'd2;
			pos_q[0] <= -18'sd65536;
			pos_q[1] <= 18'sd65536;
			pos_q[2] <= '0;
			pos_q[3] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsfe_pkg::REG_NODE_COUNT: node_count_q <= cfg_data[2:0];
				lsfe_pkg::REG_DIMENSION:  dimension_q <= cfg_data[1:0];
				default: if (cfg_index >= lsfe_pkg::REG_NODE_POS_0 &&
				             cfg_index <= lsfe_pkg::REG_NODE_POS_3)
					pos_q[2'(cfg_index - lsfe_pkg::REG_NODE_POS_0)] <= cfg_data;
			endcase
		end
	end

	logic c;
	always_comb begin
		c = (pos_q[0] == pos_q[1]);
		if (n_eff > 3'd2) c = c | (pos_q[2] == pos_q[0]) | (pos_q[2] == pos_q[1]);
		if (n_eff > 3'd3) c = c | (pos_q[3] == pos_q[0]) | (pos_q[3] == pos_q[1])
			| (pos_q[3] == pos_q[2]);
	end
	assign stat.coincide = c;
	assign stat.div_busy = dbusy | dstart_q;

	logic signed [19:0] opnd;
	logic signed [63:0] mop, mres;
	logic signed [37:0] mop_n;
	logic signed [57:0] mprod;
	logic signed [31:0] vsel;
	assign vsel = v_q[cmd.axis][cmd.j];
	always_comb begin
		opnd = '0;
		mop = num_q;
		case (cmd.op)
			lsfe_pkg::OP_NUMMUL: begin
				opnd = 20'(x_q[cmd.axis]) - 20'(pos_q[cmd.k]);
				mop = num_q;
			end
			lsfe_pkg::OP_DENMUL: begin
				opnd = 20'(pos_q[cmd.j]) - 20'(pos_q[cmd.k]);
				mop = den_q;
			end
			default: ;
		endcase
	end
	// diffs are below 2^18 in magnitude and at most three are multiplied, so the
	// running product before the last factor stays below 2^36
	assign mop_n = mop[37:0];
	assign mprod = mop_n * opnd;
	assign mres = 64'(mprod);

	logic [63:0] am, vm, pm;
	logic [47:0] pr;
	assign am = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign vm = vsel[31] ? 64'(-64'(vsel)) : 64'(vsel);
	assign pm = am[31:0] * vm[31:0];
	assign pr = 48'((pm + 64'd32768) >> 16);

	logic pneg, psat;
	assign pneg = (acc_q[63] != vsel[31]) && pr != 48'd0;
	assign psat = pneg ? (pr > 48'h80000000) : (pr > 48'h7fffffff);

	logic [63:0] nm, dm;
	assign nm = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);
	assign dm = den_q[63] ? 64'(-den_q) : 64'(den_q);

	lsfe_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart_q), .num(nm), .den(dm),
		.frac32(cmd.deriv), .busy(dbusy), .quo(dquo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dstart_q <= 1'b0;
		else dstart_q <= cmd.op == lsfe_pkg::OP_DIVGO;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q[0] <= coord_r;
			x_q[1] <= coord_s;
			x_q[2] <= coord_t;
		end
		if (dstart_q) neg_q <= sum_q[63] != den_q[63];
		case (cmd.op)
			lsfe_pkg::OP_LOAD: begin
				num_q <= 64'sd1;
				den_q <= 64'sd1;
				if (cmd.clr) sum_q <= '0;
			end
			lsfe_pkg::OP_NUMMUL: num_q <= mres;
			lsfe_pkg::OP_DENMUL: den_q <= mres;
			lsfe_pkg::OP_SUMADD: sum_q <= sum_q + num_q;
			lsfe_pkg::OP_SETACC: begin
				acc_q <= 64'(vsel);
				accf_q <= f_q[cmd.axis][cmd.j];
			end
			lsfe_pkg::OP_PMUL: begin
				accf_q <= accf_q | f_q[cmd.axis][cmd.j] | psat;
				if (pneg) acc_q <= psat ? -64'sh80000000 : -64'(pr);
				else acc_q <= psat ? 64'sh7fffffff : 64'(pr);
			end
			default: ;
		endcase
		if (wr_basis) begin
			if (neg_q) begin
				v_q[cmd.axis][cmd.j] <= dquo > 33'h80000000 ? 32'h80000000 : 32'(-dquo);
				f_q[cmd.axis][cmd.j] <= dquo > 33'h80000000;
			end else begin
				v_q[cmd.axis][cmd.j] <= dquo > 33'h7fffffff ? 32'h7fffffff : dquo[31:0];
				f_q[cmd.axis][cmd.j] <= dquo > 33'h7fffffff;
			end
		end
	end

	assign val = acc_q[31:0];
	assign flag = accf_q;
endmodule

@@ rtl/core/lsfe_ctrl.sv @@
// Controller: sequences basis evaluation and tensor products.
`timescale 1ns / 1ps
module lsfe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      deriv_axis,
	input  logic [2:0]      n_eff,
	input  logic [1:0]      d_eff,
	input  lsfe_pkg::stat_t stat,
	input  logic            out_free,
	output logic            busy,
	output lsfe_pkg::cmd_t  cmd,
	output logic            wr_basis,
	output logic            emit,
	output logic [5:0]      idx,
	output logic            is_last,
	output logic            coin
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001, S_INIT = 8'b00000010, S_NUM = 8'b00000100,
		S_SUM  = 8'b00001000, S_DEN  = 8'b00010000, S_DIV = 8'b00100000,
		S_PROD = 8'b01000000, S_EMIT = 8'b10000000
	} state_t;
	state_t st_q;
	logic [1:0] ax_q, j_q, k_q, i_q, dax_q, pa_q;
	logic [1:0] dig_q [3];
	logic [5:0] idx_q;
	logic       coin_q, dwait_q;

	logic deriv;
	assign deriv = ax_q == dax_q;
	logic [1:0] nm1;
	assign nm1 = 2'(n_eff - 3'd1);
	logic [5:0] n6;
	assign n6 = {3'd0, n_eff};
	logic [5:0] total_m1;
	assign total_m1 = (d_eff == 2'd3) ? n6 * n6 * n6 - 6'd1 : n6 * n6 - 6'd1;

	// a numerator factor is skipped at k == j, and in the derivative also at k == i
	logic kskip;
	assign kskip = (k_q == j_q) || (deriv && k_q == i_q);

	always_comb begin
		cmd = '0;
		cmd.axis = ax_q; cmd.j = j_q; cmd.k = k_q; cmd.deriv = deriv;
		case (st_q)
			S_INIT: begin cmd.op = lsfe_pkg::OP_LOAD; cmd.clr = (i_q == 2'd0); end
			S_NUM: if (!kskip) cmd.op = lsfe_pkg::OP_NUMMUL;
			S_SUM: cmd.op = lsfe_pkg::OP_SUMADD;
			S_DEN: if (k_q != j_q) cmd.op = lsfe_pkg::OP_DENMUL;
			S_DIV: if (!dwait_q) cmd.op = lsfe_pkg::OP_DIVGO;
			S_PROD: begin
				cmd.axis = pa_q; cmd.j = dig_q[pa_q];
				cmd.op = pa_q == 2'd0 ? lsfe_pkg::OP_SETACC : lsfe_pkg::OP_PMUL;
			end
			default: ;
		endcase
	end

	assign wr_basis = st_q == S_DIV && dwait_q && !stat.div_busy;
	assign busy = st_q != S_IDLE;
	assign emit = st_q == S_EMIT && out_free;
	assign idx = idx_q;
	assign is_last = idx_q == total_m1;
	assign coin = coin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ax_q <= '0; j_q <= '0; k_q <= '0; i_q <= '0; dax_q <= '0; pa_q <= '0;
			dig_q[0] <= '0; dig_q[1] <= '0; dig_q[2] <= '0;
			idx_q <= '0; coin_q <= 1'b0; dwait_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (start) begin
					dax_q <= deriv_axis; coin_q <= stat.coincide;
					ax_q <= '0; j_q <= '0; i_q <= '0; k_q <= '0; idx_q <= '0;
					pa_q <= '0;
					dig_q[0] <= '0; dig_q[1] <= '0; dig_q[2] <= '0;
					st_q <= stat.coincide ? S_EMIT : S_INIT;
				end
				S_INIT: begin
					k_q <= '0;
					// derivative: i runs over nodes other than j
					if (deriv && i_q == j_q) begin
						if (i_q == nm1) st_q <= S_DEN;
						else i_q <= i_q + 2'd1;
					end else st_q <= S_NUM;
				end
				S_NUM: begin
					if (k_q == nm1) begin
						k_q <= '0; st_q <= S_SUM;
					end else k_q <= k_q + 2'd1;
				end
				S_SUM: begin
					if (deriv && i_q != nm1 && !(i_q + 2'd1 == j_q && i_q + 2'd1 == nm1)) begin
						i_q <= (i_q + 2'd1 == j_q) ? i_q + 2'd2 : i_q + 2'd1;
						st_q <= S_INIT;
					end else st_q <= S_DEN;
				end
				S_DEN: begin
					if (k_q == nm1) begin
						k_q <= '0; st_q <= S_DIV; dwait_q <= 1'b0;
					end else k_q <= k_q + 2'd1;
				end
				S_DIV: begin
					if (!dwait_q) dwait_q <= 1'b1;
					else if (!stat.div_busy) begin
						dwait_q <= 1'b0; i_q <= '0;
						if (j_q == nm1) begin
							j_q <= '0;
							if (2'(ax_q + 2'd1) == d_eff) st_q <= S_PROD;
							else begin ax_q <= ax_q + 2'd1; st_q <= S_INIT; end
						end else begin j_q <= j_q + 2'd1; st_q <= S_INIT; end
					end
				end
				S_PROD: begin
					if (2'(pa_q + 2'd1) == d_eff) begin pa_q <= '0; st_q <= S_EMIT; end
					else pa_q <= pa_q + 2'd1;
				end
				S_EMIT: if (out_free) begin
					if (is_last) st_q <= S_IDLE;
					else begin
						idx_q <= idx_q + 6'd1;
						// odometer, last axis fastest
						if (dig_q[d_eff - 2'd1] != nm1) dig_q[d_eff - 2'd1] <= dig_q[d_eff - 2'd1] + 2'd1;
						else begin
							dig_q[d_eff - 2'd1] <= '0;
							if (dig_q[d_eff - 2'd2] != nm1) dig_q[d_eff - 2'd2] <= dig_q[d_eff - 2'd2] + 2'd1;
							else begin
								dig_q[d_eff - 2'd2] <= '0;
								dig_q[0] <= dig_q[0] + 2'd1;
							end
						end
						st_q <= coin_q ? S_EMIT : S_PROD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/core/lagrange_shape_function_eval.sv @@
// Top level of the tensor-product Lagrange shape-function evaluator.
// Usage:
//   s_axis carries one reference point per transaction; tdata holds coord_r,
//   coord_s, coord_t and deriv_axis. For each point the block returns
//   node_count^dimension results on m_axis, node index counting with the first
//   axis slowest, tlast on the final one, tuser[0] flagging saturation or
//   coincident nodes.
//   Registers are written over cfg_we/cfg_index/cfg_data; the user must
//   write them only while idle, which the block itself does not enforce.
// Sequence:
//   each point first builds the 1D basis tables: per axis and node the
//   numerator and denominator multiplies, then the bit-serial divider;
//   derivative axes repeat the numerator work n-1 times. Each result is then
//   formed on the shared product multiplier. Coincident nodes skip the
//   tables and give one result a cycle while the receiver takes them.
//   One point is processed at a time; s_axis_tready is low while busy.
// Reset: registers return to two nodes at -1 and +1 in 2D.
// Stall: a held result stops the sequencer until the receiver takes it.
`timescale 1ns / 1ps
module lagrange_shape_function_eval (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // coord_r, coord_s, coord_t, deriv_axis
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // shape_value, node_index
	output logic        m_axis_tlast,
	output logic        m_axis_tuser   // range_error
);
	logic [2:0] ncq, n_eff;
	logic [1:0] dq, d_eff;
	lsfe_pkg::cmd_t cmd;
	lsfe_pkg::stat_t stat;
	logic busy, wr_basis, emit, is_last, coin, flag, start;
	logic [5:0] idx;
	logic [31:0] val;

	assign n_eff = ncq < 3'd2 ? 3'd2 :
		(ncq > 3'(lsfe_pkg::MAX_NODES) ? 3'(lsfe_pkg::MAX_NODES) : ncq);
	assign d_eff = dq < 2'd2 ? 2'd2 :
		(dq > 2'(lsfe_pkg::MAX_DIM) ? 2'(lsfe_pkg::MAX_DIM) : dq);
	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;

	lsfe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .load(start), .coord_r(s_axis_tdata[17:0]),
		.coord_s(s_axis_tdata[35:18]), .coord_t(s_axis_tdata[53:36]),
		.n_eff(n_eff), .cmd(cmd), .wr_basis(wr_basis),
		.stat(stat), .val(val), .flag(flag), .node_count_q(ncq), .dimension_q(dq)
	);

	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	lsfe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .deriv_axis(s_axis_tdata[55:54]),
		.n_eff(n_eff), .d_eff(d_eff), .stat(stat), .out_free(out_free),
		.busy(busy), .cmd(cmd), .wr_basis(wr_basis),
		.emit(emit), .idx(idx), .is_last(is_last), .coin(coin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (emit) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_axis_tdata <= {2'b00, idx, coin ? 32'd0 : val};
			m_axis_tlast <= is_last;
			m_axis_tuser <= coin | flag;
		end
	end

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid || m_axis_tready || m_axis_tlast)
		else $error("new point accepted mid run");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> busy) else $error("result outside a run");
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the tensor-product Lagrange shape-function evaluator.
`timescale 1ns / 1ps
module testbench;
	localparam logic [2:0] REG_SPARE = 3'd6; // beyond the register list, must be ignored
	localparam int HALF = 10;

	typedef struct {
		bit               is_cfg;
		logic [2:0]       idx;
		logic [17:0]      val;
		logic [17:0]      r, s, t;
		logic [1:0]       dax;
		bit               typed;
		logic [31:0]      tval;
		bit               terr;
	} stim_row_t;

	typedef struct {
		logic [31:0] value;
		logic [5:0]  node;
		bit          last;
		bit          err;
	} shape_res_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [17:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;  // coord_r, coord_s, coord_t, deriv_axis
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // shape_value, node_index
	logic        m_axis_tlast;
	logic        m_axis_tuser;  // range_error

	lagrange_shape_function_eval dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser)
	);

	// local copy of the register file
	logic [2:0]         mdl_nodes;
	logic [1:0]         mdl_dim;
	logic signed [17:0] mdl_pos [4];

	shape_res_t  shape_q [$];
	stim_row_t   stim_tab [$];
	int          n_errors;
	bit          quiet_tx;   // stretch with no sender gaps
	bit          quiet_rx;

	initial begin
		clk = 1'b0;
		forever #HALF clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end

	task automatic report(input string msg);
		n_errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic longint unsigned mag64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// round(num * 2^frac / den), halves up, capped at 2^32
	function automatic longint unsigned ratio_q(input longint unsigned num,
			input longint unsigned den, input int frac);
		longint unsigned q, r, cap;
		cap = 64'h1_0000_0000;
		q = num / den;
		r = num % den;
		for (int b = 0; b <= frac; b++) begin
			if (q >= (cap << 1))
				return cap;
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		q = (q + 1) >> 1;
		return q >= cap ? cap : q;
	endfunction

	function automatic longint sat32(input bit neg, input longint unsigned m, inout bit flag);
		if (neg) begin
			if (m > 64'h8000_0000) begin
				flag = 1'b1;
				m = 64'h8000_0000;
			end
			return -longint'(m);
		end
		if (m > 64'h7FFF_FFFF) begin
			flag = 1'b1;
			m = 64'h7FFF_FFFF;
		end
		return longint'(m);
	endfunction

	// Builds the per-axis basis tables and queues every tensor product of the point.
	function automatic void predict_point(input logic [17:0] cr, cs, ct, input logic [1:0] dax,
			input bit typed, input logic [31:0] tval, input bit terr);
		longint x [3];
		longint v1 [3][4];
		bit f1 [3][4];
		longint nd [4];
		int n, d, total, t;
		int dig [3];
		bit coincide, flag, neg;
		longint num, den, term, acc, v;
		longint unsigned p;
		shape_res_t res;
		n = mdl_nodes < 2 ? 2 : (mdl_nodes > 4 ? 4 : mdl_nodes);
		d = mdl_dim < 2 ? 2 : mdl_dim;
		x[0] = longint'($signed(cr));
		x[1] = longint'($signed(cs));
		x[2] = longint'($signed(ct));
		coincide = 1'b0;
		for (int j = 0; j < 4; j++)
			nd[j] = longint'(mdl_pos[j]);
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (nd[i] == nd[j])
					coincide = 1'b1;
		if (!coincide) begin
			for (int a = 0; a < d; a++) begin
				for (int j = 0; j < n; j++) begin
					den = 1;
					flag = 1'b0;
					for (int k = 0; k < n; k++)
						if (k != j)
							den *= nd[j] - nd[k];
					if (a == dax) begin
						num = 0;
						for (int i = 0; i < n; i++) begin
							if (i == j)
								continue;
							term = 1;
							for (int k = 0; k < n; k++)
								if (k != j && k != i)
									term *= x[a] - nd[k];
							num += term;
						end
						v1[a][j] = sat32((num < 0) != (den < 0),
							ratio_q(mag64(num), mag64(den), 32), flag);
					end else begin
						num = 1;
						for (int k = 0; k < n; k++)
							if (k != j)
								num *= x[a] - nd[k];
						v1[a][j] = sat32((num < 0) != (den < 0),
							ratio_q(mag64(num), mag64(den), 16), flag);
					end
					f1[a][j] = flag;
				end
			end
		end
		total = 1;
		for (int a = 0; a < d; a++)
			total *= n;
		for (int idx = 0; idx < total; idx++) begin
			t = idx;
			for (int a = d - 1; a >= 0; a--) begin
				dig[a] = t % n;
				t = t / n;
			end
			acc = 0;
			flag = coincide;
			if (!coincide) begin
				acc = v1[0][dig[0]];
				flag = f1[0][dig[0]];
				for (int a = 1; a < d; a++) begin
					v = v1[a][dig[a]];
					neg = (acc < 0) != (v < 0);
					if (f1[a][dig[a]])
						flag = 1'b1;
					p = mag64(acc) * mag64(v);
					p = (p + 64'h8000) >> 16;
					acc = sat32(neg && p != 0, p, flag);
				end
			end
			res.value = typed ? tval : acc[31:0];
			res.err = typed ? terr : flag;
			res.node = idx[5:0];
			res.last = (idx + 1 == total);
			shape_q = {shape_q, res};
		end
	endfunction

	function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [17:0] val);
		stim_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	function automatic stim_row_t pt_row(input logic [17:0] r, s, t, input logic [1:0] dax,
			input bit typed = 0, input logic [31:0] tval = 0, input bit terr = 0);
		stim_row_t row;
		row = '{default: '0};
		row.r = r;
		row.s = s;
		row.t = t;
		row.dax = dax;
		row.typed = typed;
		row.tval = tval;
		row.terr = terr;
		return row;
	endfunction

	task automatic wait_idle();
		while (shape_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		case (idx)
			lsfe_pkg::REG_NODE_COUNT: mdl_nodes = val[2:0];
			lsfe_pkg::REG_DIMENSION:  mdl_dim = val[1:0];
			default: if (idx >= lsfe_pkg::REG_NODE_POS_0 && idx <= lsfe_pkg::REG_NODE_POS_3)
				mdl_pos[idx - lsfe_pkg::REG_NODE_POS_0] = val;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_point(input stim_row_t row);
		int gap;
		if (!quiet_tx) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {row.dax, row.t, row.s, row.r};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		predict_point(row.r, row.s, row.t, row.dax, row.typed, row.tval, row.terr);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 56'($urandom());
	endtask

	function automatic logic [17:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 18'($urandom());                      // full range
			1: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
			default: return 18'($signed($urandom_range(0, 131072)) - 65536);
		endcase
	endfunction

	task automatic random_setup();
		int spacing, base, i0, i1;
		logic [17:0] pos [4];
		int sel;
		sel = $urandom_range(0, 9);
		write_reg(lsfe_pkg::REG_NODE_COUNT,
			sel < 5 ? 18'd2 : (sel < 8 ? 18'd3 : 18'($urandom_range(0, 7))));
		write_reg(lsfe_pkg::REG_DIMENSION,
			$urandom_range(0, 5) == 0 ? 18'($urandom_range(0, 3)) : 18'd2);
		sel = $urandom_range(0, 9);
		spacing = $urandom_range(20000, 45000);
		base = -65536 - $urandom_range(0, 20000);
		for (int i = 0; i < 4; i++) begin
			if (sel < 7)
				pos[i] = 18'(base + i * spacing + $urandom_range(0, 999));
			else
				pos[i] = 18'($urandom());
		end
		if (sel == 9) begin
			i0 = $urandom_range(0, 3);
			i1 = $urandom_range(0, 3);
			pos[i1] = pos[i0];
		end
		for (int i = 0; i < 4; i++)
			write_reg(lsfe_pkg::REG_NODE_POS_0 + 3'(i), pos[i]);
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_SPARE + 3'($urandom_range(0, 1)), 18'($urandom()));
	endtask

	// receiver back-pressure
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (quiet_rx) begin
				m_axis_tready = 1'b1;
			end else if ($urandom_range(0, 2) == 0) begin
				m_axis_tready = 1'b0;
				gap = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
				repeat (gap - 1) @(negedge clk);
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		shape_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (shape_q.size() == 0) begin
				report($sformatf("unexpected result tdata=%h", m_axis_tdata));
			end else begin
				want = shape_q.pop_front();
				if (m_axis_tdata[31:0] !== want.value)
					report($sformatf("node %0d value %h, want %h", want.node,
						m_axis_tdata[31:0], want.value));
				if (m_axis_tdata[37:32] !== want.node)
					report($sformatf("node_index %0d, want %0d", m_axis_tdata[37:32], want.node));
				if (m_axis_tdata[39:38] !== 2'b00)
					report("tdata padding bits not zero");
				if (m_axis_tlast !== want.last)
					report($sformatf("node %0d tlast %b, want %b", want.node, m_axis_tlast,
						want.last));
				if (m_axis_tuser !== want.err)
					report($sformatf("node %0d range_error %b, want %b", want.node,
						m_axis_tuser, want.err));
			end
		end
	end

	initial begin
		stim_row_t row;
		int n_pts;
		n_errors = 0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		mdl_nodes = 3'd2;
		mdl_dim = 2'd2;
		mdl_pos[0] = -18'sd65536;
		mdl_pos[1] = 18'sd65536;
		mdl_pos[2] = '0;
		mdl_pos[3] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// centre of the default bilinear element: every node weight is one quarter
		stim_tab = {stim_tab, pt_row(18'd0, 18'd0, 18'd0, 2'd3, 1, 32'h0000_4000, 0)};
		stim_tab = {stim_tab, pt_row(18'h30000, 18'h30000, 18'd0, 2'd0)};
		stim_tab = {stim_tab, pt_row(18'h1FFFF, 18'h20000, 18'h1FFFF, 2'd1)};
		stim_tab = {stim_tab, pt_row(18'h20000, 18'h1FFFF, 18'h20000, 2'd2)};
		// two nodes on top of each other
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd1, 18'h30000)};
		stim_tab = {stim_tab, pt_row(18'd1234, 18'h3F000, 18'd0, 2'd0, 1, 32'd0, 1)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd1, 18'h10000)};
		stim_tab = {stim_tab, cfg_row(REG_SPARE, 18'h3FFFF)};
		stim_tab = {stim_tab, cfg_row(REG_SPARE + 3'd1, 18'h2AAAA)};
		stim_tab = {stim_tab, pt_row(18'd20000, 18'h3C000, 18'd0, 2'd1)};
		// register values below the legal range act as the minimum
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_COUNT, 18'd0)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_DIMENSION, 18'd0)};
		stim_tab = {stim_tab, pt_row(18'd5000, 18'd7000, 18'd0, 2'd0)};
		// four nodes, 3D, node count written above its maximum
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_COUNT, 18'h3FFFF)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_DIMENSION, 18'd3)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd2, 18'h2AAAB)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd3, 18'h15555)};
		stim_tab = {stim_tab, pt_row(18'd3000, 18'h3E000, 18'd40000, 2'd2)};
		stim_tab = {stim_tab, pt_row(18'd3000, 18'h3E000, 18'd40000, 2'd3)};
		// tightly packed nodes far from the point drive the products into saturation
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0, 18'h20000)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd1, 18'h1FFFF)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd2, 18'd1)};
		stim_tab = {stim_tab, cfg_row(lsfe_pkg::REG_NODE_POS_0 + 3'd3, 18'd2)};
		stim_tab = {stim_tab, pt_row(18'h1FFFF, 18'h20000, 18'd100, 2'd0)};
		stim_tab = {stim_tab, pt_row(18'd50000, 18'h3F000, 18'h1FFFF, 2'd3)};

		foreach (stim_tab[i]) begin
			row = stim_tab[i];
			if (row.is_cfg)
				write_reg(row.idx, row.val);
			else
				send_point(row);
		end

		n_pts = 0;
		while (n_pts < 230) begin
			random_setup();
			quiet_tx = ($urandom_range(0, 4) == 0);
			quiet_rx = ($urandom_range(0, 4) == 0);
			for (int k = $urandom_range(4, 14); k > 0; k--) begin
				if ($urandom_range(0, 3) == 0)
					row = pt_row(18'($urandom()), 18'($urandom()), 18'($urandom()),
						2'($urandom()));
				else
					row = pt_row(rand_coord(), rand_coord(), rand_coord(), 2'($urandom()));
				send_point(row);
				n_pts++;
			end
		end
		quiet_rx = 1'b0;

		while (shape_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
